// ===== hw/rtl/crc32_key_to_ring_slot_top_defines.svh =====
// Assertion macros shared by the checker of the key hashing block.
// Both macros sample on the rising clock edge and are quiet while reset is low.
`ifndef CRC32_KEY_TO_RING_SLOT_TOP_DEFINES_SVH
`define CRC32_KEY_TO_RING_SLOT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRC32KS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("crc32ks checker: property violated");

// The consequent must hold in the cycle after the antecedent.
`define CRC32KS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("crc32ks checker: property violated");

`endif

// ===== hw/rtl/crc32ks_pkg.sv =====
`default_nettype none

package crc32ks_pkg;

  // Field widths.
  localparam int unsigned CrcW       = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SlotW      = 24;
  localparam int unsigned SlotCountW = 25;

  // CRC-32 constants, reflected form.
  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB88320;
  localparam logic [CrcW-1:0] CrcInit = 32'hFFFFFFFF;

  // Slot count register.
  localparam logic [SlotCountW-1:0] SlotCountReset = 25'd1024;
  localparam logic [SlotCountW-1:0] SlotCountMax   = 25'h1000000;

  // Result queue between the front and the back. The depth is a power of two.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);

  // The remainder unit takes one dividend bit per cycle.
  localparam int unsigned DivCntW = $clog2(CrcW);

  // One finished key as it travels from the front to the back.
  typedef struct packed {
    logic [CrcW-1:0] crc;
    logic            empty_key;
  } key_res_t;

  // Back end sequencer.
  typedef enum logic [2:0] {
    BkIdle = 3'b001,
    BkDiv  = 3'b010,
    BkHold = 3'b100
  } back_state_e;

  // Advance a reflected CRC-32 by one byte, one bit per step.
  function automatic logic [CrcW-1:0] crc_advance(input logic [CrcW-1:0] crc_in,
                                                  input logic [ByteW-1:0] data);
    logic [CrcW-1:0] c;
    c = crc_in ^ {{(CrcW-ByteW){1'b0}}, data};
    for (int b = 0; b < ByteW; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc32_key_to_ring_slot_top.sv =====
// Key to ring slot hasher.
// Input channel (in_valid_i / in_ready_o) carries one key byte per transfer;
// key_end_i marks the last byte and empty_key_i stands for a zero-length key.
// Output channel (out_valid_o / out_ready_i) carries one result per key: the
// inverted CRC-32 of the key and that value modulo the slot count register.
// cfg_we_i writes the slot count from cfg_wdata_i; write it only when idle.
// Key bytes are taken one per cycle while the two-entry result queue has room.
// The slot is found by a single remainder unit that takes one CRC bit per
// cycle; per key the back end takes a key from the queue, runs 32 remainder
// steps and loads the output register. Empty keys and a zero slot count skip
// the remainder steps and give slot zero; a count above 2^24 acts as 2^24.
// When the receiver stalls, the result waits in the output register, one more
// finished key waits in the remainder unit and two more in the queue; then
// in_ready_o drops until space frees up.
// Reset clears the running CRC to all ones, empties the queue and sets the
// slot count to 1024.
`default_nettype none

module crc32_key_to_ring_slot_top import crc32ks_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ByteW-1:0]      key_byte_i,
  input  wire logic                  key_end_i,
  input  wire logic                  empty_key_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [CrcW-1:0]            key_crc_o,
  output logic [SlotW-1:0]           ring_slot_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [SlotCountW-1:0] cfg_wdata_i
);

  logic     push;
  key_res_t push_data;
  logic     full;
  logic     pop;
  key_res_t pop_data;
  logic     empty;

  // Front end: CRC accumulation and key classification.
  crc32ks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_byte_i  (key_byte_i),
    .key_end_i   (key_end_i),
    .empty_key_i (empty_key_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Queue of finished keys.
  crc32ks_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back end: slot remainder and output register.
  crc32ks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .empty_i     (empty),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .key_crc_o   (key_crc_o),
    .ring_slot_o (ring_slot_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/crc32ks_fifo.sv =====
`default_nettype none

module crc32ks_fifo import crc32ks_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire key_res_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output key_res_t      pop_data_o,
  output logic          empty_o
);

  key_res_t               mem_q [QueueDepth];
  logic [QueueIdxW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueIdxW:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == QueueDepth[QueueIdxW:0]);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill count follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crc32ks_front.sv =====
`default_nettype none

module crc32ks_front import crc32ks_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] key_byte_i,
  input  wire logic             key_end_i,
  input  wire logic             empty_key_i,
  output logic                  push_o,
  output key_res_t              push_data_o,
  input  wire logic             full_i
);

  logic [CrcW-1:0] crc_q, crc_d;
  logic [CrcW-1:0] crc_next;
  logic            xfer;

  // A byte is taken whenever the queue has room for a possible result.
  assign in_ready_o = !full_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign crc_next   = crc_advance(crc_q, key_byte_i);

  // Classify the transfer: inner byte, last byte or empty key marker.
  always_comb begin
    crc_d                 = crc_q;
    push_o                = 1'b0;
    push_data_o.crc       = ~crc_next;
    push_data_o.empty_key = 1'b0;
    if (xfer) begin
      if (empty_key_i) begin
        crc_d                 = CrcInit;
        push_o                = 1'b1;
        push_data_o.crc       = '0;
        push_data_o.empty_key = 1'b1;
      end else if (key_end_i) begin
        crc_d  = CrcInit;
        push_o = 1'b1;
      end else begin
        crc_d = crc_next;
      end
    end
  end

  // Running CRC of the key in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crc32ks_back.sv =====
`default_nettype none

module crc32ks_back import crc32ks_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [SlotCountW-1:0] cfg_wdata_i,
  input  wire logic                  empty_i,
  input  wire key_res_t              pop_data_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [CrcW-1:0]            key_crc_o,
  output logic [SlotW-1:0]           ring_slot_o
);

  back_state_e              state_q, state_d;
  logic [SlotCountW-1:0]    slot_count_q;
  logic [SlotCountW-1:0]    mod_q, mod_d;
  logic [CrcW-1:0]          div_q, div_d;
  logic [CrcW-1:0]          crc_hold_q, crc_hold_d;
  logic [SlotW-1:0]         rem_q, rem_d;
  logic [DivCntW-1:0]       cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic [CrcW-1:0]          key_crc_q;
  logic [SlotW-1:0]         ring_slot_q;
  logic [SlotCountW-1:0]    trial;
  logic [SlotCountW-1:0]    trial_sub;
  logic                     trial_ge;
  logic                     out_free;
  logic                     load_out;

  assign out_valid_o = out_valid_q;
  assign key_crc_o   = key_crc_q;
  assign ring_slot_o = ring_slot_q;

  // One restoring remainder step: shift in the next dividend bit and subtract.
  assign trial     = {rem_q, div_q[CrcW-1]};
  assign trial_ge  = (trial >= mod_q);
  assign trial_sub = trial - mod_q;

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: take a key from the queue, reduce it, then hand it to the output.
  always_comb begin
    state_d    = state_q;
    mod_d      = mod_q;
    div_d      = div_q;
    crc_hold_d = crc_hold_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    pop_o      = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          crc_hold_d = pop_data_i.crc;
          div_d      = pop_data_i.crc;
          rem_d      = '0;
          cnt_d      = '0;
          if (slot_count_q > SlotCountMax) begin
            mod_d = SlotCountMax;
          end else begin
            mod_d = slot_count_q;
          end
          // Empty keys and a zero slot count both give slot zero.
          if (pop_data_i.empty_key || (slot_count_q == '0)) begin
            state_d = BkHold;
          end else begin
            state_d = BkDiv;
          end
        end
      end
      BkDiv: begin
        rem_d = trial_ge ? trial_sub[SlotW-1:0] : trial[SlotW-1:0];
        div_d = {div_q[CrcW-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(CrcW - 1)) begin
          state_d = BkHold;
        end
      end
      BkHold: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BkIdle;
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and the slot count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BkIdle;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      slot_count_q <= SlotCountReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        slot_count_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers of the remainder unit and the output stage.
  always_ff @(posedge clk_i) begin
    mod_q      <= mod_d;
    div_q      <= div_d;
    crc_hold_q <= crc_hold_d;
    rem_q      <= rem_d;
    if (load_out) begin
      key_crc_q   <= crc_hold_q;
      ring_slot_q <= rem_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crc32ks_checker.sv =====
`default_nettype none

`include "crc32_key_to_ring_slot_top_defines.svh"

module crc32ks_checker import crc32ks_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [CrcW-1:0]       key_crc_o,
  input wire logic [SlotW-1:0]      ring_slot_o,
  input wire logic                  cfg_we_i,
  input wire logic [SlotCountW-1:0] cfg_wdata_i
);

  logic [SlotCountW-1:0] slot_shadow_q;
  logic                  slot_bounded;
  logic                  out_stalled;

  // Shadow copy of the slot count as written through the port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_shadow_q <= SlotCountReset;
    end else if (cfg_we_i) begin
      slot_shadow_q <= cfg_wdata_i;
    end
  end

  assign slot_bounded = (slot_shadow_q != '0) && (slot_shadow_q <= SlotCountMax);
  assign out_stalled  = out_valid_o && !out_ready_i;

  // A result that is not taken stays offered.
  `CRC32KS_ASSERT_NEXT(out_valid_held, out_stalled, out_valid_o)

  // A stalled result keeps its payload.
  `CRC32KS_ASSERT_NEXT(out_payload_held, out_stalled, $stable(key_crc_o) && $stable(ring_slot_o))

  // A nonzero, bounded slot count keeps the slot below it.
  `CRC32KS_ASSERT_IMPL(slot_in_range, out_valid_o && slot_bounded, {1'b0, ring_slot_o} < slot_shadow_q)

  // A zero CRC, as for an empty key, lands in slot zero.
  `CRC32KS_ASSERT_IMPL(zero_crc_slot, out_valid_o && (key_crc_o == '0), ring_slot_o == '0)

endmodule

bind crc32_key_to_ring_slot_top crc32ks_checker u_checker (.*);

`default_nettype wire
